/* rtl/core/ildec_pkg.sv */
// Package for the 8086 instruction length decoder.
// Holds the word types, the group codes, the opcode pattern table and its lookup.
// No dependencies.
package ildec_pkg;

    localparam int WINDOW_BYTES = 10;
    localparam int OP_BYTES     = 4;
    localparam int NPATS        = 129;

    typedef enum logic [4:0] {
        G_ERROR  = 5'd0,  G_DATA   = 5'd1,  G_IMPL   = 5'd2,  G_ACCIMM = 5'd3,
        G_MRIMM  = 5'd4,  G_MRMR   = 5'd5,  G_REL16  = 5'd6,  G_STR    = 5'd7,
        G_MR     = 5'd8,  G_REG16  = 5'd9,  G_INOUT  = 5'd10, G_INT    = 5'd11,
        G_ESC    = 5'd12, G_RET    = 5'd13, G_REL8   = 5'd14, G_CREL8  = 5'd15,
        G_PFX    = 5'd16, G_REGIMM = 5'd17, G_SEGMR  = 5'd18, G_ACCMEM = 5'd19,
        G_SEGREG = 5'd20, G_REGADR = 5'd21, G_SHIFT  = 5'd22, G_ACCREG = 5'd23,
        G_SEGPFX = 5'd24, G_IMPLUM = 5'd25, G_CALL16 = 5'd26, G_MEM32  = 5'd27,
        G_REGM32 = 5'd28, G_CALLF  = 5'd29, G_JMPF   = 5'd30
    } t_group;

    typedef struct packed {
        logic [15:0] base_address;
        logic [7:0]  code_byte_0;
        logic [7:0]  code_byte_1;
        logic [7:0]  code_byte_2;
        logic [7:0]  code_byte_3;
        logic [7:0]  code_byte_4;
        logic [7:0]  code_byte_5;
        logic [7:0]  code_byte_6;
        logic [7:0]  code_byte_7;
        logic [7:0]  code_byte_8;
        logic [7:0]  code_byte_9;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  group;
        logic [3:0]  length;
        logic [15:0] reference;
    } t_out_word;

    typedef struct packed {
        logic                       err;
        logic [3:0]                 pos;
        t_group                     grp;
        logic                       flag;
        logic [OP_BYTES-1:0][7:0]   b;
        logic [15:0]                base;
    } t_s2;

    typedef struct packed {
        logic [15:0] cmp;
        logic [15:0] mask;
        t_group      grp;
    } t_pat;

    localparam t_pat PATS [NPATS] = '{
        '{16'h0037,16'h00FF,G_IMPL},'{16'h0AD5,16'hFFFF,G_IMPL},
        '{16'h0AD4,16'hFFFF,G_IMPL},'{16'h003F,16'h00FF,G_IMPL},
        '{16'h0014,16'h00FE,G_ACCIMM},'{16'h1080,16'h38FC,G_MRIMM},
        '{16'h0010,16'h00FC,G_MRMR},
        '{16'h0004,16'h00FE,G_ACCIMM},'{16'h0080,16'h38FC,G_MRIMM},
        '{16'h0000,16'h00FC,G_MRMR},
        '{16'h0024,16'h00FE,G_ACCIMM},'{16'h2080,16'h38FC,G_MRIMM},
        '{16'h0020,16'h00FC,G_MRMR},
        '{16'h009A,16'h00FF,G_CALLF},'{16'h00E8,16'h00FF,G_CALL16},
        '{16'h18FF,16'h38FF,G_MEM32},'{16'h10FF,16'h38FF,G_MR},
        '{16'h0098,16'h00FF,G_IMPL},'{16'h00F8,16'h00FF,G_IMPL},
        '{16'h00FC,16'h00FF,G_IMPL},'{16'h00FA,16'h00FF,G_IMPL},
        '{16'h00F5,16'h00FF,G_IMPL},
        '{16'h003C,16'h00FE,G_ACCIMM},'{16'h3880,16'h38FC,G_MRIMM},
        '{16'h0038,16'h00FC,G_MRMR},'{16'h00A6,16'h00FE,G_STR},
        '{16'h0099,16'h00FF,G_IMPL},'{16'h0027,16'h00FF,G_IMPL},
        '{16'h002F,16'h00FF,G_IMPL},
        '{16'h08FE,16'h38FE,G_MR},'{16'h0048,16'h00F8,G_REG16},
        '{16'h30F6,16'h38FE,G_MR},'{16'h00D8,16'h00F8,G_ESC},
        '{16'h00F4,16'h00FF,G_IMPL},'{16'h38F6,16'h38FE,G_MR},
        '{16'h28F6,16'h38FE,G_MR},'{16'h00E4,16'h00F6,G_INOUT},
        '{16'h00FE,16'h38FE,G_MR},'{16'h0040,16'h00F8,G_REG16},
        '{16'h00CC,16'h00FE,G_INT},'{16'h00CE,16'h00FF,G_IMPL},
        '{16'h00CF,16'h00FF,G_RET},
        '{16'h0077,16'h00FF,G_CREL8},'{16'h0073,16'h00FF,G_CREL8},
        '{16'h0072,16'h00FF,G_CREL8},'{16'h0076,16'h00FF,G_CREL8},
        '{16'h00E3,16'h00FF,G_CREL8},'{16'h0074,16'h00FF,G_CREL8},
        '{16'h007F,16'h00FF,G_CREL8},'{16'h007D,16'h00FF,G_CREL8},
        '{16'h007C,16'h00FF,G_CREL8},'{16'h007E,16'h00FF,G_CREL8},
        '{16'h00EA,16'h00FF,G_JMPF},'{16'h00EB,16'h00FF,G_REL8},
        '{16'h00E9,16'h00FF,G_REL16},
        '{16'h28FF,16'h38FF,G_MEM32},'{16'h20FF,16'h38FF,G_MR},
        '{16'h0075,16'h00FF,G_CREL8},'{16'h0071,16'h00FF,G_CREL8},
        '{16'h007B,16'h00FF,G_CREL8},'{16'h0079,16'h00FF,G_CREL8},
        '{16'h0070,16'h00FF,G_CREL8},'{16'h007A,16'h00FF,G_CREL8},
        '{16'h0078,16'h00FF,G_CREL8},
        '{16'h009F,16'h00FF,G_IMPL},'{16'h00C5,16'h00FF,G_REGM32},
        '{16'h008D,16'h00FF,G_REGADR},'{16'h00C4,16'h00FF,G_REGM32},
        '{16'h00F0,16'h00FF,G_PFX},'{16'h00AC,16'h00FE,G_STR},
        '{16'h00E2,16'h00FF,G_CREL8},'{16'h00E1,16'h00FF,G_CREL8},
        '{16'h00E0,16'h00FF,G_CREL8},
        '{16'h0088,16'h00FC,G_MRMR},'{16'h00B0,16'h00F0,G_REGIMM},
        '{16'h00A0,16'h00FC,G_ACCMEM},'{16'h008C,16'h20FD,G_SEGMR},
        '{16'h00C6,16'h38FE,G_MRIMM},'{16'h00A4,16'h00FE,G_STR},
        '{16'h20F6,16'h38FE,G_MR},'{16'h18F6,16'h38FE,G_MR},
        '{16'h0090,16'h00FF,G_IMPL},'{16'h10F6,16'h38FE,G_MR},
        '{16'h000C,16'h00FE,G_ACCIMM},'{16'h0880,16'h38FC,G_MRIMM},
        '{16'h0008,16'h00FC,G_MRMR},
        '{16'h00E6,16'h00F6,G_INOUT},
        '{16'h008F,16'h38FF,G_MR},'{16'h0058,16'h00F8,G_REG16},
        '{16'h0007,16'h00E7,G_SEGREG},'{16'h009D,16'h00FF,G_IMPL},
        '{16'h30FF,16'h38FF,G_MR},'{16'h0050,16'h00F8,G_REG16},
        '{16'h0006,16'h00E7,G_SEGREG},'{16'h009C,16'h00FF,G_IMPL},
        '{16'h10D0,16'h38FC,G_SHIFT},'{16'h18D0,16'h38FC,G_SHIFT},
        '{16'h00F2,16'h00FF,G_PFX},'{16'h00F3,16'h00FF,G_PFX},
        '{16'h00CA,16'h00FE,G_RET},'{16'h00C2,16'h00FE,G_RET},
        '{16'h00D0,16'h38FC,G_SHIFT},'{16'h08D0,16'h38FC,G_SHIFT},
        '{16'h009E,16'h00FF,G_IMPL},'{16'h38D0,16'h38FC,G_SHIFT},
        '{16'h001C,16'h00FE,G_ACCIMM},'{16'h1880,16'h38FC,G_MRIMM},
        '{16'h0018,16'h00FC,G_MRMR},
        '{16'h00AE,16'h00FE,G_STR},'{16'h0026,16'h00E7,G_SEGPFX},
        '{16'h20D0,16'h38FC,G_SHIFT},'{16'h28D0,16'h38FC,G_SHIFT},
        '{16'h00F9,16'h00FF,G_IMPL},'{16'h00FD,16'h00FF,G_IMPL},
        '{16'h00FB,16'h00FF,G_IMPL},
        '{16'h00AA,16'h00FE,G_STR},
        '{16'h002C,16'h00FE,G_ACCIMM},'{16'h2880,16'h38FC,G_MRIMM},
        '{16'h0028,16'h00FC,G_MRMR},
        '{16'h00A8,16'h00FE,G_ACCIMM},'{16'h00F6,16'h38FE,G_MRIMM},
        '{16'h0084,16'h00FE,G_MRMR},
        '{16'h009B,16'h00FF,G_IMPL},'{16'h0090,16'h00F8,G_ACCREG},
        '{16'h0086,16'h00FE,G_REGADR},'{16'h00D7,16'h00FF,G_IMPLUM},
        '{16'h0034,16'h00FE,G_ACCIMM},'{16'h3080,16'h38FC,G_MRIMM},
        '{16'h0030,16'h00FC,G_MRMR}
    };

    // Returns the group in the upper bits and a flag in bit 0: for implied
    // forms an extra operand byte, for immediate forms a sign-extendable entry.
    function automatic logic [5:0] pat_lookup(input logic [15:0] w);
        logic [5:0] res;
        res = {G_DATA, 1'b0};
        for (int i = NPATS - 1; i >= 0; i--) begin
            if ((w & PATS[i].mask) == PATS[i].cmp) begin
                res = {PATS[i].grp, (PATS[i].grp == G_IMPL) ? (PATS[i].mask[15:8] != 8'h00)
                                                            : !PATS[i].mask[1]};
            end
        end
        return res;
    endfunction

    function automatic logic is_prefix(input logic [7:0] b);
        return (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3) || ((b & 8'hE7) == 8'h26);
    endfunction

endpackage

/* rtl/core/ildec_exec.sv */
// Final decode stage: operand length, referenced address and output register.
// Depends on ildec_pkg.
module ildec_exec (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ildec_pkg::t_s2        i_s2,
    input  logic [15:0]           i_load_offset,
    output logic                  o_done,
    output ildec_pkg::t_out_word  o_word
);
    import ildec_pkg::*;

    logic        r_done, n_done;
    t_out_word   r_word, n_word;
    logic [7:0]  op, mrm;
    logic [15:0] d16a, d16b, rel8;
    logic [2:0]  mlen, rel;
    logic [15:0] mref, ref_v;
    logic [4:0]  n;

    always_comb begin
        op   = i_s2.b[0];
        mrm  = i_s2.b[1];
        d16a = {i_s2.b[2], i_s2.b[1]};
        d16b = {i_s2.b[3], i_s2.b[2]};
        rel8 = {{8{i_s2.b[1][7]}}, i_s2.b[1]};
        mlen = 3'd1;
        mref = '0;
        if (mrm[7:6] == 2'd2) begin
            mlen = 3'd3;
            mref = (d16b > i_load_offset && i_load_offset != 16'd0) ? d16b : 16'd0;
        end else if (mrm[7:6] == 2'd1) begin
            mlen = 3'd2;
        end else if (mrm[7:6] == 2'd0 && mrm[2:0] == 3'd6) begin
            mlen = 3'd3;
            mref = d16b;
        end
        rel   = 3'd1;
        ref_v = '0;
        case (i_s2.grp)
            G_IMPL:   rel = 3'd1 + 3'(i_s2.flag);
            G_ACCIMM: rel = 3'd2 + 3'(op[0]);
            G_MRIMM: begin
                rel   = 3'd2 + mlen + 3'(!(i_s2.flag && op[1]) && op[0]);
                ref_v = mref;
            end
            G_MRMR, G_REGADR, G_REGM32, G_MR, G_MEM32, G_ESC, G_SEGMR, G_SHIFT: begin
                rel   = 3'd1 + mlen;
                ref_v = mref;
            end
            G_CALL16, G_REL16: begin
                rel   = 3'd3;
                ref_v = i_s2.base + 16'(i_s2.pos) + 16'd3 + d16a;
            end
            G_INOUT:  rel = op[3] ? 3'd1 : 3'd2;
            G_INT: begin
                rel   = op[0] ? 3'd2 : 3'd1;
                ref_v = op[0] ? {8'h00, i_s2.b[1]} : 16'd3;
            end
            G_RET:    rel = op[0] ? 3'd1 : 3'd3;
            G_CREL8, G_REL8: begin
                rel   = 3'd2;
                ref_v = i_s2.base + 16'(i_s2.pos) + 16'd2 + rel8;
            end
            G_REGIMM: rel = 3'd2 + 3'(op[3]);
            G_ACCMEM: begin
                rel   = 3'd3;
                ref_v = d16a;
            end
            G_CALLF, G_JMPF: rel = 3'd5;
            default:  rel = 3'd1;
        endcase
        n = 5'(i_s2.pos) + 5'(rel);
    end

    always_comb begin
        n_done = i_valid;
        if (i_s2.err || n > 5'(WINDOW_BYTES)) begin
            n_word = '0;
        end else begin
            n_word.group     = i_s2.grp;
            n_word.length    = n[3:0];
            n_word.reference = ref_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_word <= n_word;
    end

    assign o_done = r_done;
    assign o_word = r_word;

endmodule

/* rtl/core/i8086_instruction_length_decoder.sv */
// Top level of the 8086 instruction length decoder: prefix scan and table match stages.
// Depends on ildec_pkg and ildec_exec.
// start is registered via r_v1, r_v2 and r_done; one word is accepted every cycle.
// The three register stages are prefix scan, opcode table match and operand decode.
// busy stays low. Reset clears the stage valid bits and sets load_offset to 0x0100.
module i8086_instruction_length_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ildec_pkg::t_in_word   i_word,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    output logic                  o_done,
    output ildec_pkg::t_out_word  o_word
);
    import ildec_pkg::*;

    logic [15:0]                      r_load_offset;
    logic [WINDOW_BYTES-1:0][7:0]     win;
    logic [3:0]                       n_pos;
    logic                             r_v1, r_v2;
    logic [3:0]                       r_pos1;
    logic [WINDOW_BYTES-1:0][7:0]     r_win1;
    logic [15:0]                      r_base1;
    t_s2                              r_s2, n_s2;
    logic [4:0]                       idx [OP_BYTES];
    logic [5:0]                       hit;

    assign win = {i_word.code_byte_9, i_word.code_byte_8, i_word.code_byte_7,
                  i_word.code_byte_6, i_word.code_byte_5, i_word.code_byte_4,
                  i_word.code_byte_3, i_word.code_byte_2, i_word.code_byte_1,
                  i_word.code_byte_0};

    always_comb begin
        n_pos = 4'(WINDOW_BYTES);
        for (int i = WINDOW_BYTES - 1; i >= 0; i--) begin
            if (!is_prefix(win[i])) begin
                n_pos = 4'(i);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < OP_BYTES; j++) begin
            idx[j]    = 5'(r_pos1) + 5'(j);
            n_s2.b[j] = (idx[j] < 5'(WINDOW_BYTES)) ? r_win1[idx[j][3:0]] : 8'h00;
        end
        hit       = pat_lookup({n_s2.b[1], n_s2.b[0]});
        n_s2.grp  = t_group'(hit[5:1]);
        n_s2.flag = hit[0];
        n_s2.err  = (r_pos1 == 4'(WINDOW_BYTES));
        n_s2.pos  = r_pos1;
        n_s2.base = r_base1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_offset <= 16'h0100;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_load_offset <= i_cfg_wdata;
            end
            r_v1 <= start;
            r_v2 <= r_v1;
        end
        r_pos1  <= n_pos;
        r_win1  <= win;
        r_base1 <= i_word.base_address;
        r_s2    <= n_s2;
    end

    ildec_exec u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_v2),
        .i_s2          (r_s2),
        .i_load_offset (r_load_offset),
        .o_done        (o_done),
        .o_word        (o_word)
    );

    assign busy = 1'b0;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> o_done) else $error("decoded word lost");
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v2 |=> !o_done) else $error("spurious result strobe");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.group == G_ERROR) |-> (o_word.length == 4'd0 &&
        o_word.reference == 16'd0)) else $error("error word not cleared");
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.group != G_ERROR) |-> (o_word.length != 4'd0))
        else $error("zero length for a decoded instruction");

endmodule

/* sim/i8086_instruction_length_decoder_tb.sv */
// Testbench for the 8086 instruction length decoder: directed and random code windows
// are driven through the start/busy port and each result word is checked against a predictor.
// Depends on ildec_pkg and the decoder RTL.
module i8086_instruction_length_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ildec_pkg::*;

    localparam int LATENCY = 3;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_word   i_word;
    logic       i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic       o_done;
    t_out_word  o_word;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    logic [15:0] origin;
    int unsigned error_count;
    bit stim_done;
    bit driver_hold;
    int unsigned gap_left;
    int unsigned burst_left;

    i8086_instruction_length_decoder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_word(i_word), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_word(o_word)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] win_byte(t_in_word w, int unsigned idx);
        logic [79:0] bytes;
        bytes = w[79:0];
        if (idx >= WINDOW_BYTES) return 8'h00;
        return bytes[(9 - idx) * 8 +: 8];
    endfunction

    function automatic logic [15:0] win_pair(t_in_word w, int unsigned idx);
        return {win_byte(w, idx + 1), win_byte(w, idx)};
    endfunction

    function automatic logic [15:0] modrm_ref(t_in_word w, ref int unsigned n,
                                              input logic [15:0] org);
        logic [7:0] b;
        logic [15:0] d;
        b = win_byte(w, n);
        n++;
        if (b[7:6] == 2'd2) begin
            d = win_pair(w, n);
            n += 2;
            return (d > org && org != 0) ? d : 16'h0000;
        end
        if (b[7:6] == 2'd1) begin
            n++;
            return 16'h0000;
        end
        if (b[7:6] == 2'd0 && b[2:0] == 3'd6) begin
            d = win_pair(w, n);
            n += 2;
            return d;
        end
        return 16'h0000;
    endfunction

    function automatic t_out_word decode_length(t_in_word w, logic [15:0] org);
        t_out_word res;
        int unsigned p, n, i, k;
        logic [15:0] wd, rf, disp;
        logic [7:0] op;
        logic [7:0] db;
        t_group grp;
        bit ok, sx;
        p = 0; n = 0; ok = 0; rf = 0; grp = G_DATA;
        for (k = 0; k < 16 && p < WINDOW_BYTES; k++) begin
            wd = win_pair(w, p);
            for (i = 0; i < NPATS; i++)
                if ((wd & PATS[i].mask) == PATS[i].cmp) break;
            op = wd[7:0];
            n = p + 1;
            if (i >= NPATS) begin
                grp = G_DATA;
                ok = 1;
                break;
            end
            grp = PATS[i].grp;
            if (grp == G_PFX || grp == G_SEGPFX) begin
                p = n;
                continue;
            end
            ok = 1;
            case (grp)
                G_IMPL: if (PATS[i].mask[15:8] != 0) n++;
                G_ACCIMM: n += 1 + op[0];
                G_MRIMM: begin
                    sx = !PATS[i].mask[1] && op[1];
                    rf = modrm_ref(w, n, org);
                    n += 1 + ((!sx && op[0]) ? 1 : 0);
                end
                G_MRMR, G_REGADR, G_REGM32, G_MR, G_MEM32, G_ESC, G_SEGMR, G_SHIFT:
                    rf = modrm_ref(w, n, org);
                G_CALL16, G_REL16: begin
                    disp = win_pair(w, n);
                    n += 2;
                    rf = w.base_address + n[15:0] + disp;
                end
                G_INOUT: if (!op[3]) n++;
                G_INT: begin
                    if (op[0]) begin
                        rf = {8'h00, win_byte(w, n)};
                        n++;
                    end else begin
                        rf = 16'd3;
                    end
                end
                G_RET: if (!op[0]) n += 2;
                G_CREL8, G_REL8: begin
                    db = win_byte(w, n);
                    disp = {{8{db[7]}}, db};
                    n++;
                    rf = w.base_address + n[15:0] + disp;
                end
                G_REGIMM: n += 1 + op[3];
                G_ACCMEM: begin
                    rf = win_pair(w, n);
                    n += 2;
                end
                G_CALLF, G_JMPF: n += 4;
                default: ;
            endcase
            break;
        end
        if (!ok || n > WINDOW_BYTES) begin
            res = '0;
        end else begin
            res.group = grp;
            res.length = n[3:0];
            res.reference = rf;
        end
        return res;
    endfunction

    function automatic t_in_word make_window(logic [7:0] b0, logic [7:0] b1, bit prefixed);
        t_in_word w;
        logic [79:0] bytes;
        int unsigned np, i;
        for (i = 0; i < 10; i++) bytes[i * 8 +: 8] = 8'($urandom_range(0, 255));
        np = prefixed ? $urandom_range(1, 3) : 0;
        for (i = 0; i < np; i++) begin
            case ($urandom_range(0, 6))
                0: bytes[(9 - i) * 8 +: 8] = 8'hF0;
                1: bytes[(9 - i) * 8 +: 8] = 8'hF2;
                2: bytes[(9 - i) * 8 +: 8] = 8'hF3;
                default: bytes[(9 - i) * 8 +: 8] = 8'h26 | 8'($urandom_range(0, 3) << 3);
            endcase
        end
        bytes[(9 - np) * 8 +: 8] = b0;
        bytes[(8 - np) * 8 +: 8] = b1;
        w.base_address = 16'($urandom_range(0, 65535));
        w[79:0] = bytes;
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_origin(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        origin = value;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || driver_hold) begin
            start <= 1'b0;
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (pending_words.size() != 0) begin
            i_word <= pending_words[0];
            start <= 1'b1;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && start && !busy) begin
            expected_words.push_back(decode_length(pending_words.pop_front(), origin));
        end
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", {7'd0, o_word.group, o_word.length}, 16'h0);
            end else begin
                want = expected_words.pop_front();
                if (o_word.group !== want.group)
                    report_mismatch("group", 16'(o_word.group), 16'(want.group));
                if (o_word.length !== want.length)
                    report_mismatch("length", 16'(o_word.length), 16'(want.length));
                if (o_word.reference !== want.reference)
                    report_mismatch("reference", o_word.reference, want.reference);
            end
        end
    end

    initial begin
        logic [15:0] origins[5];
        logic [7:0] b0;
        t_in_word w;
        origins = '{16'h0000, 16'hFFFF, 16'h0100, 16'h8000, 16'h0001};
        start = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        origin = 16'h0100;
        error_count = 0;
        stim_done = 0;
        driver_hold = 0;
        gap_left = 0;
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        w = '0;
        pending_words.push_back(w);
        w = '1;
        pending_words.push_back(w);
        w = {16'hFFFF, 8'hE8, 8'hFF, 8'h7F, 56'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'h74, 8'h80, 64'h0};
        pending_words.push_back(w);
        w = {16'hFFFE, 8'hEB, 8'h7F, 64'h0};
        pending_words.push_back(w);
        w = {16'h1234, 8'hCC, 8'hCD, 64'h0};
        pending_words.push_back(w);
        w = {16'h1234, 8'hCD, 8'h21, 64'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'hA1, 8'h34, 8'h12, 56'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'h8B, 8'h86, 8'h00, 8'h02, 48'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'h8B, 8'h06, 8'hCD, 8'hAB, 48'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'hD5, 8'h0A, 64'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'hD5, 8'h0B, 64'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'h83, 8'h06, 8'h00, 8'h10, 8'h05, 40'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'h81, 8'h86, 8'h00, 8'h90, 8'h34, 8'h12, 32'h0};
        pending_words.push_back(w);
        w = {16'h0000, {9{8'hF3}}, 8'h90};
        pending_words.push_back(w);
        w = {16'h0000, {10{8'hF0}}};
        pending_words.push_back(w);
        w = {16'h0000, {7{8'h26}}, 8'h81, 8'h06, 8'h00};
        pending_words.push_back(w);
        w = {16'h0000, 8'h2E, 8'hF0, 8'h0F, 56'h0};
        pending_words.push_back(w);
        w = {16'h0000, {6{8'h00}}, 8'hF2, 8'hEA, 8'h00, 8'h00};
        pending_words.push_back(w);
        w = {16'hABCD, 8'h9A, 8'h11, 8'h22, 8'h33, 8'h44, 40'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'hC2, 8'h04, 8'h00, 56'h0};
        pending_words.push_back(w);
        w = {16'h0000, 8'hE4, 8'h60, 8'hEC, 56'h0};
        pending_words.push_back(w);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            set_origin(origins[phase]);
            for (int i = 0; i < 80; i++) begin
                case ($urandom_range(0, 9))
                    0: w = make_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       1'b0);
                    1: begin
                        w = make_window(8'h8B, 8'h80 | 8'($urandom_range(0, 63)), 1'b1);
                    end
                    2: w = make_window(8'h80 | 8'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    3: w = make_window(8'hC4 | 8'($urandom_range(0, 11)),
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    4: begin
                        w = '0;
                        for (int j = 0; j < 10; j++)
                            w[j * 8 +: 8] = ($urandom_range(0, 1)) ? 8'hF3 : 8'h2E;
                        w[$urandom_range(0, 9) * 8 +: 8] = 8'($urandom_range(0, 255));
                    end
                    default: begin
                        b0 = 8'($urandom_range(0, 255));
                        w = make_window(b0, 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)));
                    end
                endcase
                pending_words.push_back(w);
                if (phase == 2 && i == 40) begin
                    driver_hold = 1;
                    while (expected_words.size() != 0 || start) @(posedge i_clk);
                    driver_hold = 0;
                end
            end
            wait_idle();
        end
        stim_done = 1;
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/ildec_pkg.sv
rtl/core/ildec_exec.sv
rtl/core/i8086_instruction_length_decoder.sv
sim/i8086_instruction_length_decoder_tb.sv
